[sv/swr_pkg.sv]
// ----------------------------------------------------------------------------
// swr_pkg: shared types and constants of the stop-and-wait receiver
// Item and result types, verdict codes, header word positions and limits.
// ----------------------------------------------------------------------------
package swr_pkg;

  // widths of the stream fields
  localparam int unsigned WORD_W     = 16;
  localparam int unsigned SEQ_W      = 8;
  localparam int unsigned CKSUM_W    = 16;
  localparam int unsigned PAYLOAD_W  = 12;
  localparam int unsigned TOTAL_W    = 24;
  localparam int unsigned INDEX_W    = 11;
  localparam int unsigned OUT_DATA_W = 64;

  // packet layout and limits
  localparam int unsigned DATA_BYTES   = 2048;
  localparam int unsigned PAYLOAD_MAX  = (1 << PAYLOAD_W) - 1;
  localparam int unsigned PAYLOAD_CAP  = (DATA_BYTES < PAYLOAD_MAX) ? DATA_BYTES : PAYLOAD_MAX;
  localparam logic [INDEX_W-1:0] INDEX_MAX   = '1;
  localparam logic [INDEX_W-1:0] IDX_SEQ_LO  = INDEX_W'(0);
  localparam logic [INDEX_W-1:0] IDX_SEQ_HI  = INDEX_W'(1);
  localparam logic [INDEX_W-1:0] IDX_LENGTH  = INDEX_W'(5);
  localparam logic [INDEX_W-1:0] IDX_FLAGS   = INDEX_W'(6);

  // flag byte bits
  localparam int unsigned FLAG_END_BIT = 3;
  localparam logic [CKSUM_W-1:0] FLAG_ACK = CKSUM_W'(2);

  // sequence space after reset
  localparam logic [SEQ_W-1:0] SEQ_MODULUS_RST = SEQ_W'(2);
  localparam logic [SEQ_W-1:0] REJECT_SEQ_RST  = SEQ_W'(1);

  typedef enum logic [1:0] {
    VERDICT_ACCEPT = 2'd0,
    VERDICT_REACK  = 2'd1,
    VERDICT_END    = 2'd2
  } verdict_t;

  // one received word
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              last;
  } item_t;

  // header view including the word being processed
  typedef struct packed {
    logic [31:0]       seq;
    logic [WORD_W-1:0] length;
    logic [7:0]        flags;
    logic              sum_ok;
  } pkt_view_t;

  // one verdict transaction
  typedef struct packed {
    verdict_t             verdict;
    logic [SEQ_W-1:0]     ack_number;
    logic [CKSUM_W-1:0]   ack_checksum;
    logic [PAYLOAD_W-1:0] payload_bytes;
    logic [TOTAL_W-1:0]   total_bytes;
  } result_t;

endpackage

[sv/swr_word_track.sv]
// ----------------------------------------------------------------------------
// swr_word_track: per-word packet tracking
// Keeps the ones-complement sum, word position and latched header fields.
// ----------------------------------------------------------------------------
module swr_word_track (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  swr_pkg::item_t     item,
  output swr_pkg::pkt_view_t view
);

  logic [swr_pkg::INDEX_W-1:0] index_r, index_nxt;
  logic [swr_pkg::WORD_W-1:0]  sum_r, sum_nxt;
  logic [31:0]                 seq_r;
  logic [swr_pkg::WORD_W-1:0]  length_r;
  logic [7:0]                  flags_r;
  logic [swr_pkg::WORD_W:0]    sum_wide;
  logic [swr_pkg::WORD_W-1:0]  sum_fold;

  // header fields as seen after this word, cleared at the first word
  always_comb begin
    if (index_r == swr_pkg::IDX_SEQ_LO) begin
      view.seq    = '0;
      view.length = '0;
      view.flags  = '0;
    end else begin
      view.seq    = seq_r;
      view.length = length_r;
      view.flags  = flags_r;
    end
    if (index_r == swr_pkg::IDX_SEQ_LO) begin
      view.seq[15:0] = item.word;
    end else if (index_r == swr_pkg::IDX_SEQ_HI) begin
      view.seq[31:16] = item.word;
    end else if (index_r == swr_pkg::IDX_LENGTH) begin
      view.length = item.word;
    end else if (index_r == swr_pkg::IDX_FLAGS) begin
      view.flags = item.word[7:0];
    end
    view.sum_ok = (sum_fold == '1);
  end

  // end-around carry add
  always_comb begin
    sum_wide = {1'b0, sum_r} + {1'b0, item.word};
    if (sum_wide[swr_pkg::WORD_W]) begin
      sum_fold = sum_wide[swr_pkg::WORD_W-1:0] + swr_pkg::WORD_W'(1);
    end else begin
      sum_fold = sum_wide[swr_pkg::WORD_W-1:0];
    end
  end

  // framing restarts after the last word
  always_comb begin
    if (item.last) begin
      sum_nxt   = '0;
      index_nxt = '0;
    end else begin
      sum_nxt   = sum_fold;
      index_nxt = (index_r == swr_pkg::INDEX_MAX) ? index_r
                                                   : index_r + swr_pkg::INDEX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      index_r  <= '0;
      sum_r    <= '0;
      seq_r    <= '0;
      length_r <= '0;
      flags_r  <= '0;
    end else if (fire) begin
      index_r  <= index_nxt;
      sum_r    <= sum_nxt;
      seq_r    <= view.seq;
      length_r <= view.length;
      flags_r  <= view.flags;
    end
  end

endmodule

[sv/swr_verdict.sv]
// ----------------------------------------------------------------------------
// swr_verdict: end-of-packet decision and result register
// Owns the sequence counters and the byte total; holds one result.
// ----------------------------------------------------------------------------
module swr_verdict (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     fire,
  input  logic                     last,
  input  swr_pkg::pkt_view_t       view,
  input  logic [swr_pkg::SEQ_W-1:0] seq_modulus,
  input  logic                     out_ready,
  output logic                     out_valid,
  output swr_pkg::result_t         result
);

  logic [swr_pkg::SEQ_W-1:0]   reject_seq_r, reject_seq_nxt;
  logic [swr_pkg::SEQ_W-1:0]   next_ack_r, next_ack_nxt;
  logic [swr_pkg::TOTAL_W-1:0] total_r, total_nxt;
  logic                        out_valid_r, out_valid_nxt;
  swr_pkg::result_t            result_r, result_nxt;
  logic [swr_pkg::SEQ_W:0]     modulus;
  logic [swr_pkg::SEQ_W:0]     reject_inc, ack_inc;
  logic [swr_pkg::PAYLOAD_W-1:0] payload;
  logic [swr_pkg::TOTAL_W:0]   total_sum;
  logic [swr_pkg::TOTAL_W-1:0] total_sat;
  logic                        is_end, is_reack;
  logic                        done;

  assign done = fire && last;

  // wrap-increment of both counters, modulus below two acts as two
  always_comb begin
    modulus    = (seq_modulus < swr_pkg::SEQ_W'(2)) ? (swr_pkg::SEQ_W + 1)'(2)
                                                    : {1'b0, seq_modulus};
    reject_inc = {1'b0, reject_seq_r} + (swr_pkg::SEQ_W + 1)'(1);
    ack_inc    = {1'b0, next_ack_r} + (swr_pkg::SEQ_W + 1)'(1);
  end

  // payload clamp and saturating total
  always_comb begin
    payload   = (view.length < swr_pkg::WORD_W'(swr_pkg::PAYLOAD_CAP))
                ? view.length[swr_pkg::PAYLOAD_W-1:0]
                : swr_pkg::PAYLOAD_W'(swr_pkg::PAYLOAD_CAP);
    total_sum = {1'b0, total_r} + (swr_pkg::TOTAL_W + 1)'(payload);
    total_sat = total_sum[swr_pkg::TOTAL_W] ? '1 : total_sum[swr_pkg::TOTAL_W-1:0];
  end

  // verdict and counter updates
  always_comb begin
    is_end   = view.flags[swr_pkg::FLAG_END_BIT];
    is_reack = (view.seq == {24'd0, reject_seq_r}) || !view.sum_ok;

    reject_seq_nxt = reject_seq_r;
    next_ack_nxt   = next_ack_r;
    total_nxt      = total_r;
    result_nxt     = result_r;

    priority if (is_end) begin
      result_nxt.verdict       = swr_pkg::VERDICT_END;
      result_nxt.ack_number    = '0;
      result_nxt.payload_bytes = '0;
      result_nxt.total_bytes   = total_r;
      total_nxt                = '0;
    end else if (is_reack) begin
      result_nxt.verdict       = swr_pkg::VERDICT_REACK;
      result_nxt.ack_number    = reject_seq_r;
      result_nxt.payload_bytes = '0;
      result_nxt.total_bytes   = total_r;
    end else begin
      result_nxt.verdict       = swr_pkg::VERDICT_ACCEPT;
      result_nxt.ack_number    = next_ack_r;
      result_nxt.payload_bytes = payload;
      result_nxt.total_bytes   = total_sat;
      total_nxt                = total_sat;
      reject_seq_nxt = (reject_inc >= modulus) ? '0 : reject_inc[swr_pkg::SEQ_W-1:0];
      next_ack_nxt   = (ack_inc >= modulus) ? '0 : ack_inc[swr_pkg::SEQ_W-1:0];
    end

    // ack packet checksum: ack number plus the ack flag, inverted
    result_nxt.ack_checksum = ~({8'd0, result_nxt.ack_number} + swr_pkg::FLAG_ACK);
  end

  // result register handshake
  always_comb begin
    if (done) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reject_seq_r <= swr_pkg::REJECT_SEQ_RST;
      next_ack_r   <= '0;
      total_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (done) begin
        reject_seq_r <= reject_seq_nxt;
        next_ack_r   <= next_ack_nxt;
        total_r      <= total_nxt;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (done) begin
      result_r <= result_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign result    = result_r;

endmodule

[sv/stop_and_wait_receiver.sv]
// ----------------------------------------------------------------------------
// stop_and_wait_receiver: alternating-bit packet receiver
// Checks packet words, latches the header and gives one verdict per packet.
//
//   channel  direction  handshake             contents
//   in_      slave      in_tvalid/in_tready   tdata word, tlast end of packet
//   out_     master     out_tvalid/out_tready tdata verdict transaction
//   cfg_     slave      cfg_valid/cfg_ready   seq_modulus
//
// One word per cycle is accepted unless the input stalls; each word is held in
// the input register, where the sum/header/verdict logic works on it ahead of the
// result register. The verdict of a packet is registered there from its last word.
// Non-last words keep flowing while a result waits; a last word stalls the
// input only when the result register is still full and not being taken.
// rst_n is synchronous; after reset the modulus is 2 and no result is pending.
// ----------------------------------------------------------------------------
module stop_and_wait_receiver (
  input  logic        clk,
  input  logic        rst_n,
  // packet words
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] word
  input  logic        in_tlast,
  // verdicts
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [1:0] verdict, [9:2] ack_number,
                                  // [25:10] ack_checksum, [37:26] payload_bytes,
                                  // [61:38] total_bytes, [63:62] zero
  // sequence modulus register
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  logic                            s1_valid_r, s1_valid_nxt;
  swr_pkg::item_t                  s1_item_r;
  logic [swr_pkg::SEQ_W-1:0]       seq_modulus_r;
  logic                            proc_ok;
  logic                            fire;
  logic                            in_fire;
  swr_pkg::pkt_view_t              view;
  swr_pkg::result_t                result;

  // a last word needs the result register free or draining
  assign proc_ok   = !s1_item_r.last || !out_tvalid || out_tready;
  assign fire      = s1_valid_r && proc_ok;
  assign in_tready = !s1_valid_r || proc_ok;
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // input register
  always_comb begin
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (fire) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      seq_modulus_r <= swr_pkg::SEQ_MODULUS_RST;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        seq_modulus_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r.word <= in_tdata;
      s1_item_r.last <= in_tlast;
    end
  end

  swr_word_track u_word_track (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (s1_item_r),
    .view  (view)
  );

  swr_verdict u_verdict (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .last        (s1_item_r.last),
    .view        (view),
    .seq_modulus (seq_modulus_r),
    .out_ready   (out_tready),
    .out_valid   (out_tvalid),
    .result      (result)
  );

  // pack the verdict transaction, first field lowest
  assign out_tdata = {2'b00,
                      result.total_bytes,
                      result.payload_bytes,
                      result.ack_checksum,
                      result.ack_number,
                      result.verdict};

endmodule
